@@ rtl/ubcp_pkg.sv @@
// shared types and constants for the u barrier corner point block
`timescale 1ns / 1ps

package ubcp_pkg;

  // coordinate width, signed q.8 metres
  localparam int COORD_WIDTH   = 32;
  localparam int RADIUS_WIDTH  = 18;
  localparam int CLOSING_WIDTH = 24;
  localparam int MARGIN_WIDTH  = 18;
  localparam int CFG_WIDTH     = 24;

  // minimum along-track length, 10 m in q.8
  localparam int MIN_ALONG_Q8 = 2560;

  // register indexes
  typedef enum logic [0:0] {
    CFG_CLOSING_LENGTH = 1'b0,
    CFG_SIDE_MARGIN    = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] own_x;
    logic signed [COORD_WIDTH-1:0] own_y;
    logic signed [COORD_WIDTH-1:0] target_x;
    logic signed [COORD_WIDTH-1:0] target_y;
    logic [RADIUS_WIDTH-1:0]       target_radius;
    logic                          pass_right;
  } query_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] first_corner_x;
    logic signed [COORD_WIDTH-1:0] first_corner_y;
    logic signed [COORD_WIDTH-1:0] second_corner_x;
    logic signed [COORD_WIDTH-1:0] second_corner_y;
    logic signed [COORD_WIDTH-1:0] closing_end_x;
    logic signed [COORD_WIDTH-1:0] closing_end_y;
    logic                          saturated;
  } corners_t;

endpackage

@@ rtl/ubcp_isqrt.sv @@
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps

module ubcp_isqrt #(
  parameter int DW  = 33,
  parameter int SBW = 8
) (
  input  logic                clk,
  input  logic                en,
  input  logic [2*DW-1:0]     n_i,
  input  logic [SBW-1:0]      sb_i,
  output logic [DW-1:0]       root_o,
  output logic [SBW-1:0]      sb_o
);

  localparam int NW = 2 * DW;

  logic [NW-1:0]  rem_r  [DW];
  logic [DW-1:0]  root_r [DW];
  logic [SBW-1:0] sb_r   [DW];

  // stage i decides root bit DW-1-i from the running residue
  for (genvar i = 0; i < DW; i++) begin : g_stage
    localparam int B = DW - 1 - i;
    logic [NW-1:0]  rem_in;
    logic [NW-1:0]  trial;
    logic [DW-1:0]  root_in;
    logic [SBW-1:0] sb_in;

    if (i == 0) begin : g_first
      assign rem_in  = n_i;
      assign root_in = '0;
      assign sb_in   = sb_i;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign sb_in   = sb_r[i-1];
    end

    // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
    assign trial = (NW'(root_in) << (B + 1)) | (NW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem_r[i]  <= rem_in - trial;
          root_r[i] <= root_in | (DW'(1) << B);
        end else begin
          rem_r[i]  <= rem_in;
          root_r[i] <= root_in;
        end
        sb_r[i] <= sb_in;
      end
    end
  end

  assign root_o = root_r[DW-1];
  assign sb_o   = sb_r[DW-1];

endmodule

@@ rtl/ubcp_udiv.sv @@
// pipelined restoring divider for both unit vector components
`timescale 1ns / 1ps

module ubcp_udiv #(
  parameter int DW  = 33,
  parameter int F   = 16,
  parameter int SBW = 8
) (
  input  logic            clk,
  input  logic            en,
  input  logic [DW-1:0]   ax_i,
  input  logic [DW-1:0]   ay_i,
  input  logic [DW-1:0]   d_i,
  input  logic [SBW-1:0]  sb_i,
  output logic [F:0]      qx_o,
  output logic [F:0]      qy_o,
  output logic [DW-1:0]   d_o,
  output logic [SBW-1:0]  sb_o
);

  logic [DW-1:0]  rx_r [F+1];
  logic [DW-1:0]  ry_r [F+1];
  logic [F:0]     qx_r [F+1];
  logic [F:0]     qy_r [F+1];
  logic [DW-1:0]  d_r  [F+1];
  logic [SBW-1:0] sb_r [F+1];

  // integer bit: subtract once, then keep the residue below d
  logic          gx0, gy0;
  logic [DW-1:0] rx0, ry0;

  always_comb begin
    gx0 = ax_i >= d_i;
    gy0 = ay_i >= d_i;
    rx0 = gx0 ? ax_i - d_i : ax_i;
    ry0 = gy0 ? ay_i - d_i : ay_i;
    if (rx0 >= d_i) rx0 = d_i - DW'(1);
    if (ry0 >= d_i) ry0 = d_i - DW'(1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r[0] <= rx0;
      ry_r[0] <= ry0;
      qx_r[0] <= (F+1)'(gx0);
      qy_r[0] <= (F+1)'(gy0);
      d_r[0]  <= d_i;
      sb_r[0] <= sb_i;
    end
  end

  // one fraction bit per stage
  for (genvar k = 1; k <= F; k++) begin : g_frac
    logic [DW:0] tx, ty;
    logic        gx, gy;

    assign tx = {rx_r[k-1], 1'b0};
    assign ty = {ry_r[k-1], 1'b0};
    assign gx = tx >= {1'b0, d_r[k-1]};
    assign gy = ty >= {1'b0, d_r[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rx_r[k] <= gx ? DW'(tx - {1'b0, d_r[k-1]}) : DW'(tx);
        ry_r[k] <= gy ? DW'(ty - {1'b0, d_r[k-1]}) : DW'(ty);
        qx_r[k] <= {qx_r[k-1][F-1:0], gx};
        qy_r[k] <= {qy_r[k-1][F-1:0], gy};
        d_r[k]  <= d_r[k-1];
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  assign qx_o = qx_r[F];
  assign qy_o = qy_r[F];
  assign d_o  = d_r[F];
  assign sb_o = sb_r[F];

endmodule

@@ rtl/u_barrier_corner_points_top.sv @@
// top level of the u barrier corner point pipeline
`timescale 1ns / 1ps

// Usage: present a query item on in_data with in_valid; it is taken on a
// clock edge where in_valid and in_ready are both high. Each query yields
// one corners item on out_data, in order, handed over with out_valid and
// out_ready. The pipeline has three front stages (differences, squares,
// sum), one stage per root bit of the 33-bit square root, UNIT_FRAC_BITS
// + 1 divider stages, and five stages for lengths, products, and the three
// clamped points. A new item is accepted every cycle in which in_ready is
// high. The whole pipeline advances as one while the output register
// is empty or being taken; when the receiver stalls, in_ready falls and every
// item holds in place. Reset empties the pipeline and sets closing_length to
// 999 m and side_margin to 77 (q.8). Registers are written through cfg_we,
// cfg_index and cfg_data, and should change only while the block is empty.

module u_barrier_corner_points_top #(
  parameter int UNIT_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ubcp_pkg::query_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ubcp_pkg::corners_t                  out_data,
  input  logic                                cfg_we,
  input  ubcp_pkg::cfg_index_t                cfg_index,
  input  logic [ubcp_pkg::CFG_WIDTH-1:0]      cfg_data
);

  import ubcp_pkg::*;

  localparam int F    = UNIT_FRAC_BITS;
  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int NW   = 2 * DW;
  localparam int L1W  = MARGIN_WIDTH + 1;
  localparam int L2W  = ((DW > RADIUS_WIDTH + 2) ? DW : RADIUS_WIDTH + 2) + 1;
  localparam int PW   = L2W + F + 1;
  localparam int SVW  = L2W + 2;
  localparam int SMW  = ((CW > SVW) ? CW : SVW) + 1;

  typedef struct packed {
    logic                    valid;
    logic                    sx;
    logic                    sy;
    logic [DW-1:0]           mx;
    logic [DW-1:0]           my;
    logic signed [CW-1:0]    tx;
    logic signed [CW-1:0]    ty;
    logic [RADIUS_WIDTH-1:0] r;
    logic                    right;
  } side_t;

  localparam int SBW = $bits(side_t);

  // floor(len * comp / 2^F) from the product magnitude and sign
  function automatic logic signed [SVW-1:0] scale_q(input logic [PW-1:0] p,
                                                    input logic neg);
    logic [SVW-1:0] m;
    m = SVW'(p >> F) + SVW'(|p[F-1:0] & neg);
    return neg ? -$signed(m) : $signed(m);
  endfunction

  // clamp to the coordinate range, flag in the top bit
  function automatic logic [CW:0] clamp_q(input logic signed [SMW-1:0] v);
    logic hi_o, lo_o;
    hi_o = !v[SMW-1] && (v[SMW-2:CW-1] != '0);
    lo_o = v[SMW-1] && (v[SMW-2:CW-1] != '1);
    if (hi_o) return {1'b1, 1'b0, {(CW-1){1'b1}}};
    if (lo_o) return {1'b1, 1'b1, {(CW-1){1'b0}}};
    return {1'b0, v[CW-1:0]};
  endfunction

  logic adv;
  logic out_valid_r;
  corners_t out_data_r;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration registers
  logic [CLOSING_WIDTH-1:0] closing_r;
  logic [MARGIN_WIDTH-1:0]  margin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      closing_r <= CLOSING_WIDTH'(255744);
      margin_r  <= MARGIN_WIDTH'(77);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLOSING_LENGTH: closing_r <= cfg_data[CLOSING_WIDTH-1:0];
        CFG_SIDE_MARGIN:    margin_r  <= cfg_data[MARGIN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: differences and magnitudes
  logic signed [CW:0] dx, dy;
  side_t s1_r, s2_r, s3_r;

  assign dx = $signed({in_data.target_x[CW-1], in_data.target_x})
            - $signed({in_data.own_x[CW-1], in_data.own_x});
  assign dy = $signed({in_data.target_y[CW-1], in_data.target_y})
            - $signed({in_data.own_y[CW-1], in_data.own_y});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else if (adv) begin
      s1_r.valid <= in_valid;
    end
    if (adv) begin
      s1_r.sx    <= dx[CW];
      s1_r.sy    <= dy[CW];
      s1_r.mx    <= dx[CW] ? DW'(-dx) : DW'(dx);
      s1_r.my    <= dy[CW] ? DW'(-dy) : DW'(dy);
      s1_r.tx    <= in_data.target_x;
      s1_r.ty    <= in_data.target_y;
      s1_r.r     <= in_data.target_radius;
      s1_r.right <= in_data.pass_right;
    end
  end

  // stage 2: squares; stage 3: sum
  logic [NW-1:0] sqx_r, sqy_r, n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
    end else if (adv) begin
      s2_r.valid <= s1_r.valid;
      s3_r.valid <= s2_r.valid;
    end
    if (adv) begin
      sqx_r <= NW'(s1_r.mx) * NW'(s1_r.mx);
      sqy_r <= NW'(s1_r.my) * NW'(s1_r.my);
      {s2_r.sx, s2_r.sy, s2_r.mx, s2_r.my, s2_r.tx, s2_r.ty, s2_r.r, s2_r.right} <=
        {s1_r.sx, s1_r.sy, s1_r.mx, s1_r.my, s1_r.tx, s1_r.ty, s1_r.r, s1_r.right};
      n_r <= sqx_r + sqy_r;
      {s3_r.sx, s3_r.sy, s3_r.mx, s3_r.my, s3_r.tx, s3_r.ty, s3_r.r, s3_r.right} <=
        {s2_r.sx, s2_r.sy, s2_r.mx, s2_r.my, s2_r.tx, s2_r.ty, s2_r.r, s2_r.right};
    end
  end

  // distance, then unit vector division
  logic [DW-1:0]  root;
  logic [SBW-1:0] sq_sb, dv_sb;
  side_t          sq_s, dv_s;
  logic [F:0]     qx, qy;
  logic [DW-1:0]  dv_d;

  ubcp_isqrt #(.DW(DW), .SBW(SBW)) u_isqrt (
    .clk    (clk),
    .en     (adv),
    .n_i    (n_r),
    .sb_i   (SBW'(s3_r)),
    .root_o (root),
    .sb_o   (sq_sb)
  );

  // keep bubbles from carrying stale valid bits out of reset
  logic [DW+F:0] vpipe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vpipe_r <= '0;
    end else if (adv) begin
      vpipe_r <= {vpipe_r[DW+F-1:0], s3_r.valid};
    end
  end

  assign sq_s = side_t'(sq_sb);

  ubcp_udiv #(.DW(DW), .F(F), .SBW(SBW)) u_udiv (
    .clk  (clk),
    .en   (adv),
    .ax_i (sq_s.mx),
    .ay_i (sq_s.my),
    .d_i  (root),
    .sb_i (sq_sb),
    .qx_o (qx),
    .qy_o (qy),
    .d_o  (dv_d),
    .sb_o (dv_sb)
  );

  assign dv_s = side_t'(dv_sb);

  // stage 4: unit vector signs and the two leg lengths
  logic                    s4_valid_r;
  logic [F:0]              uxm_r, uym_r;
  logic                    uxn_r, uyn_r, right4_r;
  logic [L1W-1:0]          l1_r;
  logic [L2W-1:0]          l2_r;
  logic signed [CW-1:0]    tx4_r, ty4_r;
  logic                    dzero;
  logic [L2W-1:0]          dmax;

  assign dzero = dv_d == '0;
  assign dmax  = (L2W'(dv_d) > L2W'(MIN_ALONG_Q8)) ? L2W'(dv_d) : L2W'(MIN_ALONG_Q8);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r <= vpipe_r[DW+F] & dv_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      uxm_r    <= dzero ? (F+1)'(1) << F : qx;
      uym_r    <= dzero ? '0 : qy;
      uxn_r    <= !dzero && dv_s.sx;
      uyn_r    <= !dzero && dv_s.sy;
      right4_r <= dv_s.right;
      l1_r     <= L1W'(margin_r) + L1W'(dv_s.r);
      l2_r     <= dmax + (L2W'(dv_s.r) << 1) + L2W'(dv_s.r);
      tx4_r    <= dv_s.tx;
      ty4_r    <= dv_s.ty;
    end
  end

  // stage 5: six length by component products
  logic            pxn, pyn;
  logic [F:0]      pxm, pym;
  logic            s5_valid_r;
  logic [PW-1:0]   m1x_r, m1y_r, m2x_r, m2y_r, m3x_r, m3y_r;
  logic            pxn_r, pyn_r, uxn5_r, uyn5_r;
  logic signed [CW-1:0] tx5_r, ty5_r;

  assign pxm = uym_r;
  assign pym = uxm_r;
  assign pxn = right4_r ? !uyn_r : uyn_r;
  assign pyn = right4_r ? uxn_r : !uxn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (adv) begin
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1x_r  <= PW'(l1_r) * PW'(pxm);
      m1y_r  <= PW'(l1_r) * PW'(pym);
      m2x_r  <= PW'(l2_r) * PW'(uxm_r);
      m2y_r  <= PW'(l2_r) * PW'(uym_r);
      m3x_r  <= PW'(closing_r) * PW'(pxm);
      m3y_r  <= PW'(closing_r) * PW'(pym);
      pxn_r  <= pxn;
      pyn_r  <= pyn;
      uxn5_r <= uxn_r;
      uyn5_r <= uyn_r;
      tx5_r  <= tx4_r;
      ty5_r  <= ty4_r;
    end
  end

  // stage 6: first corner
  logic                  s6_valid_r, sat6_r;
  logic signed [CW-1:0]  p1x_r, p1y_r;
  logic signed [SVW-1:0] v2x_r, v2y_r, v3x6_r, v3y6_r;
  logic [CW:0]           c1x, c1y;

  assign c1x = clamp_q(SMW'(tx5_r) + SMW'(scale_q(m1x_r, pxn_r)));
  assign c1y = clamp_q(SMW'(ty5_r) + SMW'(scale_q(m1y_r, pyn_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r <= 1'b0;
    end else if (adv) begin
      s6_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1x_r  <= c1x[CW-1:0];
      p1y_r  <= c1y[CW-1:0];
      sat6_r <= c1x[CW] | c1y[CW];
      v2x_r  <= scale_q(m2x_r, uxn5_r);
      v2y_r  <= scale_q(m2y_r, uyn5_r);
      v3x6_r <= scale_q(m3x_r, pxn_r);
      v3y6_r <= scale_q(m3y_r, pyn_r);
    end
  end

  // stage 7: second corner
  logic                  s7_valid_r, sat7_r;
  logic signed [CW-1:0]  p1x7_r, p1y7_r, p3x_r, p3y_r;
  logic signed [SVW-1:0] v3x_r, v3y_r;
  logic [CW:0]           c3x, c3y;

  assign c3x = clamp_q(SMW'(p1x_r) - SMW'(v2x_r));
  assign c3y = clamp_q(SMW'(p1y_r) - SMW'(v2y_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_valid_r <= 1'b0;
    end else if (adv) begin
      s7_valid_r <= s6_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1x7_r <= p1x_r;
      p1y7_r <= p1y_r;
      p3x_r  <= c3x[CW-1:0];
      p3y_r  <= c3y[CW-1:0];
      sat7_r <= sat6_r | c3x[CW] | c3y[CW];
      v3x_r  <= v3x6_r;
      v3y_r  <= v3y6_r;
    end
  end

  // stage 8: closing end, output register
  logic [CW:0] c5x, c5y;

  assign c5x = clamp_q(SMW'(p3x_r) - SMW'(v3x_r));
  assign c5y = clamp_q(SMW'(p3y_r) - SMW'(v3y_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s7_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.first_corner_x  <= p1x7_r;
      out_data_r.first_corner_y  <= p1y7_r;
      out_data_r.second_corner_x <= p3x_r;
      out_data_r.second_corner_y <= p3y_r;
      out_data_r.closing_end_x   <= c5x[CW-1:0];
      out_data_r.closing_end_y   <= c5y[CW-1:0];
      out_data_r.saturated       <= sat7_r | c5x[CW] | c5y[CW];
    end
  end

endmodule
